/* sv/ffa_pkg.sv */
package ffa_pkg;

    localparam int ARENA_BYTES  = 1048576;
    localparam int HEADER_BYTES = 16;
    localparam int HDR          = ((HEADER_BYTES + 7) / 8) * 8;
    localparam int WORDS        = ARENA_BYTES / 8;
    localparam int IDX_W        = $clog2(WORDS);
    localparam int CNT_W        = IDX_W + 1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOMEM   = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    typedef struct packed {
        logic             mark;
        logic [20:0]      size;
        logic             nv;
        logic [IDX_W-1:0] next;
    } t_hdr;

endpackage

/* sv/ffa_hdr_ram.sv */
module ffa_hdr_ram import ffa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_hdr             i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_hdr             o_rdata
);

    t_hdr r_mem [WORDS];
    t_hdr r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/first_fit_free_list_allocator.sv */
// zero-size allocate, allocate on an empty list, null free and a free rejected
// on range or alignment are answered from idle; any other free reads its header first
// allocate: S_ARD reads the first header, S_WALK follows the free list and writes the taken
// header, then S_REST writes a split remainder and S_LINK the predecessor link, as needed
// one request at a time; busy, when raised, stays high until the result strobe; no stall
// synchronous active-low reset empties the free list, arena built on first allocate
module first_fit_free_list_allocator import ffa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [20:0] i_req_size,
    input  logic [19:0] i_user_addr,
    output logic        o_done,
    output logic [19:0] o_addr,
    output logic [1:0]  o_status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ARD  = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_REST = 3'd3;
    localparam logic [2:0] S_LINK = 3'd4;
    localparam logic [2:0] S_FCHK = 3'd5;

    localparam logic [IDX_W-1:0] HDR_IDX = IDX_W'(HDR / 8);

    logic [2:0]       r_state, n_state;
    logic [21:0]      r_need, n_need;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic [IDX_W-1:0] r_prev, n_prev;
    t_hdr             r_prev_w, n_prev_w;
    logic             r_at_head, n_at_head;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_head, n_head;
    logic             r_head_v, n_head_v;
    logic             r_ready, n_ready;
    logic [IDX_W-1:0] r_rest, n_rest;
    t_hdr             r_rest_w, n_rest_w;
    logic             r_split, n_split;
    logic             r_done, n_done;
    logic [19:0]      r_addr, n_addr;
    logic [1:0]       r_status, n_status;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    t_hdr             wdata, rdata;

    logic [20:0]      free_off;
    logic [22:0]      need_hdr;
    logic             whole;
    logic [IDX_W-1:0] rest_idx;
    logic             lk_nv;
    logic [IDX_W-1:0] lk_next;
    logic [20:0]      fsize;

    ffa_hdr_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign free_off = {1'b0, i_user_addr} - 21'(HDR);
    assign need_hdr = {1'b0, r_need} + 23'(HDR);
    assign whole    = need_hdr >= {2'b0, rdata.size};
    assign rest_idx = r_cur + HDR_IDX + r_need[IDX_W+2:3];

    always_comb begin
        n_state   = r_state;
        n_need    = r_need;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_prev_w  = r_prev_w;
        n_at_head = r_at_head;
        n_cnt     = r_cnt;
        n_head    = r_head;
        n_head_v  = r_head_v;
        n_ready   = r_ready;
        n_rest    = r_rest;
        n_rest_w  = r_rest_w;
        n_split   = r_split;
        n_done    = 1'b0;
        n_addr    = r_addr;
        n_status  = r_status;
        we        = 1'b0;
        waddr     = r_cur;
        wdata     = '0;
        raddr     = r_cur;
        lk_nv     = 1'b0;
        lk_next   = '0;
        fsize     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (!i_mode) begin
                        n_cnt     = '0;
                        n_at_head = 1'b1;
                        n_need    = ({1'b0, i_req_size} + 22'd7) & ~22'd7;
                        if (i_req_size == '0) begin
                            n_done   = 1'b1;
                            n_status = ST_ZERO;
                            n_addr   = '0;
                        end else if (!r_ready) begin
                            we         = 1'b1;
                            waddr      = '0;
                            wdata.size = 21'(ARENA_BYTES - HDR);
                            n_head     = '0;
                            n_head_v   = 1'b1;
                            n_ready    = 1'b1;
                            n_cur      = '0;
                            n_state    = S_ARD;
                        end else if (!r_head_v) begin
                            n_done   = 1'b1;
                            n_status = ST_NOMEM;
                            n_addr   = '0;
                        end else begin
                            n_cur   = r_head;
                            n_state = S_ARD;
                        end
                    end else begin
                        if (i_user_addr == '0 || !r_ready) begin
                            n_done   = 1'b1;
                            n_status = ST_OK;
                            n_addr   = '0;
                        end else if (i_user_addr < 20'(HDR) || free_off[2:0] != 3'd0
                                     || free_off >= 21'(ARENA_BYTES)) begin
                            n_done   = 1'b1;
                            n_status = ST_BADFREE;
                            n_addr   = '0;
                        end else begin
                            raddr   = free_off[IDX_W+2:3];
                            n_cur   = free_off[IDX_W+2:3];
                            n_state = S_FCHK;
                        end
                    end
                end
            end
            S_ARD: begin
                raddr   = r_cur;
                n_state = S_WALK;
            end
            S_WALK: begin
                if ({1'b0, rdata.size} >= r_need) begin
                    if (whole) begin
                        lk_nv   = rdata.nv;
                        lk_next = rdata.next;
                        fsize   = rdata.size;
                    end else begin
                        lk_nv   = 1'b1;
                        lk_next = rest_idx;
                        fsize   = r_need[20:0];
                    end
                    n_rest        = rest_idx;
                    n_rest_w.mark = 1'b0;
                    n_rest_w.size = rdata.size - r_need[20:0] - 21'(HDR);
                    n_rest_w.nv   = rdata.nv;
                    n_rest_w.next = rdata.next;
                    n_split       = !whole;
                    we            = 1'b1;
                    waddr         = r_cur;
                    wdata.mark    = 1'b1;
                    wdata.size    = fsize;
                    n_addr        = {r_cur, 3'b000} + 20'(HDR);
                    if (r_at_head) begin
                        n_head   = lk_next;
                        n_head_v = lk_nv;
                    end else begin
                        n_prev_w.nv   = lk_nv;
                        n_prev_w.next = lk_next;
                    end
                    if (!whole) begin
                        n_state = S_REST;
                    end else if (!r_at_head) begin
                        n_state = S_LINK;
                    end else begin
                        n_state  = S_IDLE;
                        n_done   = 1'b1;
                        n_status = ST_OK;
                    end
                end else if (!rdata.nv || r_cnt == CNT_W'(WORDS)) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = ST_NOMEM;
                    n_addr   = '0;
                end else begin
                    n_prev    = r_cur;
                    n_prev_w  = rdata;
                    n_at_head = 1'b0;
                    n_cur     = rdata.next;
                    raddr     = rdata.next;
                    n_cnt     = r_cnt + CNT_W'(1);
                end
            end
            S_REST: begin
                we    = 1'b1;
                waddr = r_rest;
                wdata = r_rest_w;
                if (!r_at_head) begin
                    n_state = S_LINK;
                end else begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = ST_OK;
                end
            end
            S_LINK: begin
                we       = 1'b1;
                waddr    = r_prev;
                wdata    = r_prev_w;
                n_state  = S_IDLE;
                n_done   = 1'b1;
                n_status = ST_OK;
            end
            S_FCHK: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                n_addr  = '0;
                if (!rdata.mark) begin
                    n_status = ST_BADFREE;
                end else begin
                    we         = 1'b1;
                    waddr      = r_cur;
                    wdata.size = rdata.size;
                    wdata.nv   = r_head_v;
                    wdata.next = r_head;
                    n_head     = r_cur;
                    n_head_v   = 1'b1;
                    n_status   = ST_OK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head_v <= 1'b0;
            r_ready  <= 1'b0;
            r_done   <= 1'b0;
            r_head   <= '0;
        end else begin
            r_state  <= n_state;
            r_head_v <= n_head_v;
            r_ready  <= n_ready;
            r_done   <= n_done;
            r_head   <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_need    <= n_need;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_prev_w  <= n_prev_w;
        r_at_head <= n_at_head;
        r_cnt     <= n_cnt;
        r_rest    <= n_rest;
        r_rest_w  <= n_rest_w;
        r_split   <= n_split;
        r_addr    <= n_addr;
        r_status  <= n_status;
    end

    assign busy     = r_state != S_IDLE;
    assign o_done   = r_done;
    assign o_addr   = r_addr;
    assign o_status = r_status;

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result beat while busy");
    a_fail_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_OK |-> o_addr == '0) else $error("failed beat with address");
    a_head_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_v |-> r_ready) else $error("free list without arena");
    a_ready_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |=> r_ready) else $error("arena setup lost");
    a_rest_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_REST |-> r_split) else $error("remainder write without split");
`endif

endmodule
